@@ rtl/core/quoted_printable_encoder_assert.svh @@
// assertion macros shared by the quoted-printable encoder modules
`ifndef QUOTED_PRINTABLE_ENCODER_ASSERT_SVH
`define QUOTED_PRINTABLE_ENCODER_ASSERT_SVH
`ifndef SYNTHESIS
`define QPE_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("qpe property violated");
`define QPE_NEVER(label, clk, rst_n, expr) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
		else $error("qpe forbidden condition seen");
`else
`define QPE_ASSERT(label, clk, rst_n, prop)
`define QPE_NEVER(label, clk, rst_n, expr)
`endif
`endif

@@ rtl/core/qpe_pkg.sv @@
// types, character constants and helper functions of the quoted-printable encoder
package qpe_pkg;

	typedef struct packed {
		logic       kind;
		logic [7:0] data_byte;
	} qpe_in_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       run_last;
	} qpe_out_t;

	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_SP    = 8'h20;
	localparam logic [7:0] CH_BANG  = 8'h21;
	localparam logic [7:0] CH_TILDE = 8'h7E;
	localparam logic [7:0] CH_EQ    = "=";
	localparam logic [7:0] CH_F     = "F";
	localparam logic [7:0] CH_R     = "r";
	localparam logic [7:0] CH_O     = "o";
	localparam logic [7:0] CH_M     = "m";
	localparam logic [7:0] CH_4     = "4";
	localparam logic [7:0] CH_6     = "6";
	localparam logic [7:0] CH_ZERO  = "0";
	localparam logic [7:0] CH_HEX_A = 8'h37;

	localparam logic [7:0] LIMIT_RESET = 8'd76;
	localparam logic [7:0] LIMIT_MIN   = 8'd8;

	// output segments of one command, sent lowest first
	typedef enum logic [2:0] {
		SEG_PRE   = 3'd0,
		SEG_SOFT  = 3'd1,
		SEG_BODY  = 3'd2,
		SEG_BLANK = 3'd3,
		SEG_NL    = 3'd4
	} seg_t;
	localparam int NUM_SEGS = 5;

	typedef enum logic [1:0] {
		PRE_HELD  = 2'd0,
		PRE_OWED  = 2'd1,
		PRE_MATCH = 2'd2
	} pre_kind_t;

	localparam logic [2:0] OWED_LEN  = 3'd3;
	localparam logic [2:0] MATCH_LEN = 3'd6;

	typedef struct packed {
		logic [NUM_SEGS-1:0] segs;
		pre_kind_t           pre_kind;
		logic [2:0]          pre_len;
		logic                body_hex;
		logic [7:0]          body_byte;
	} qpe_cmd_t;

	function automatic logic [7:0] hex_digit(input logic [3:0] n);
		if (n < 4'd10) begin
			return CH_ZERO + {4'b0, n};
		end
		return CH_HEX_A + {4'b0, n};
	endfunction

	function automatic logic [7:0] from_char(input logic [1:0] idx);
		logic [7:0] c;
		unique case (idx)
			2'd0: c = CH_F;
			2'd1: c = CH_R;
			2'd2: c = CH_O;
			2'd3: c = CH_M;
		endcase
		return c;
	endfunction

	function automatic logic is_blank(input logic [7:0] b);
		return (b == CH_SP) || (b == CH_TAB);
	endfunction

	function automatic logic is_plain(input logic [7:0] b);
		return is_blank(b) || ((b >= CH_BANG) && (b <= CH_TILDE) && (b != CH_EQ));
	endfunction

	// characters of the prefix segment: held "From" bytes, owed "=\n ", or "=46rom"
	function automatic logic [7:0] pre_char(input pre_kind_t kind, input logic [2:0] idx);
		logic [7:0] c;
		unique case (kind)
			PRE_HELD: c = from_char(idx[1:0]);
			PRE_OWED: begin
				unique case (idx)
					3'd0:    c = CH_EQ;
					3'd1:    c = CH_LF;
					default: c = CH_SP;
				endcase
			end
			PRE_MATCH: begin
				unique case (idx)
					3'd0:    c = CH_EQ;
					3'd1:    c = CH_4;
					3'd2:    c = CH_6;
					3'd3:    c = CH_R;
					3'd4:    c = CH_O;
					default: c = CH_M;
				endcase
			end
			default: c = CH_SP;
		endcase
		return c;
	endfunction

endpackage

@@ rtl/core/qpe_front.sv @@
// front end: takes input items, tracks line state and turns each item into a command
`include "quoted_printable_encoder_assert.svh"
module qpe_front import qpe_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     cfg_valid,
	output logic     cfg_ready,
	input  logic [7:0] cfg_data,
	input  logic     src_valid,
	output logic     src_stall,
	input  qpe_in_t  src_data,
	output logic     cmd_push,
	output qpe_cmd_t cmd,
	input  logic     cmd_full
);

	localparam logic [2:0] PFX_START    = 3'd0;
	localparam logic [2:0] PFX_HELD_MAX = 3'd4;
	localparam logic [2:0] PFX_PAST     = 3'd5;
	localparam logic [2:0] PFX_OWED     = 3'd6;
	localparam logic [7:0] MATCH_COL    = 8'd6;
	localparam logic [8:0] BREAK_ROOM   = 9'd3;

	logic [7:0] limit_q;
	logic [7:0] column_q;
	logic [2:0] prefix_q;
	logic       blank_q;
	logic       endnl_q;

	logic [7:0] column_d;
	logic [2:0] prefix_d;
	logic       blank_d;
	logic       endnl_d;

	logic [7:0] limit_eff;
	logic       held;
	logic       owed;
	logic       accept;
	logic       soft_brk;
	logic [7:0] base_col;
	logic [7:0] body_col;

	assign cfg_ready = 1'b1;
	assign src_stall = cmd_full;
	assign accept    = src_valid && !cmd_full;
	assign cmd_push  = accept && (cmd.segs != '0);

	assign limit_eff = (limit_q < LIMIT_MIN) ? LIMIT_MIN : limit_q;
	assign held      = (prefix_q != PFX_START) && (prefix_q <= PFX_HELD_MAX);
	assign owed      = (prefix_q == PFX_OWED);

	always_comb begin
		cmd          = '0;
		cmd.pre_kind = PRE_HELD;
		column_d     = column_q;
		prefix_d     = prefix_q;
		blank_d      = blank_q;
		endnl_d      = endnl_q;
		soft_brk     = 1'b0;
		base_col     = column_q;
		body_col     = column_q;

		// held or owed bytes go out first on a line end, a file end or a mismatch
		if (held) begin
			cmd.pre_kind = PRE_HELD;
			cmd.pre_len  = prefix_q;
		end else if (owed) begin
			cmd.pre_kind = PRE_OWED;
			cmd.pre_len  = OWED_LEN;
		end

		if (src_data.kind) begin
			cmd.segs[SEG_PRE] = held || owed;
			cmd.segs[SEG_NL]  = !endnl_q;
			column_d = '0;
			prefix_d = PFX_START;
			blank_d  = 1'b0;
			endnl_d  = 1'b0;
		end else if (src_data.data_byte == CH_LF) begin
			cmd.segs[SEG_PRE]   = held || owed;
			cmd.segs[SEG_BLANK] = owed || (!held && blank_q);
			cmd.segs[SEG_NL]    = 1'b1;
			column_d = '0;
			prefix_d = PFX_START;
			blank_d  = 1'b0;
			endnl_d  = 1'b1;
		end else begin
			endnl_d = 1'b0;
			if ((prefix_q < PFX_HELD_MAX) && (src_data.data_byte == from_char(prefix_q[1:0]))) begin
				prefix_d = prefix_q + 3'd1;
			end else if ((prefix_q == PFX_HELD_MAX) && (src_data.data_byte == CH_SP)) begin
				cmd.segs[SEG_PRE] = 1'b1;
				cmd.pre_kind      = PRE_MATCH;
				cmd.pre_len       = MATCH_LEN;
				if ({1'b0, MATCH_COL} + BREAK_ROOM > {1'b0, limit_eff}) begin
					// soft break and space carried over to the next item
					prefix_d = PFX_OWED;
					column_d = MATCH_COL;
					blank_d  = 1'b0;
				end else begin
					cmd.segs[SEG_BODY] = 1'b1;
					cmd.body_byte      = CH_SP;
					prefix_d = PFX_PAST;
					column_d = MATCH_COL + 8'd1;
					blank_d  = 1'b1;
				end
			end else begin
				cmd.segs[SEG_PRE] = held || owed;
				if (owed) begin
					base_col = 8'd1;
				end else if (held) begin
					base_col = {5'b0, prefix_q};
				end
				// a flush leaves the column short enough that no break is needed
				soft_brk = !held && !owed &&
					({1'b0, column_q} + BREAK_ROOM > {1'b0, limit_eff});
				body_col           = soft_brk ? '0 : base_col;
				cmd.segs[SEG_SOFT] = soft_brk;
				cmd.segs[SEG_BODY] = 1'b1;
				cmd.body_hex       = !is_plain(src_data.data_byte);
				cmd.body_byte      = src_data.data_byte;
				column_d = body_col + (cmd.body_hex ? 8'd3 : 8'd1);
				blank_d  = is_blank(src_data.data_byte);
				prefix_d = PFX_PAST;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q  <= LIMIT_RESET;
			column_q <= '0;
			prefix_q <= PFX_START;
			blank_q  <= 1'b0;
			endnl_q  <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				limit_q <= cfg_data;
			end
			if (accept) begin
				column_q <= column_d;
				prefix_q <= prefix_d;
				blank_q  <= blank_d;
				endnl_q  <= endnl_d;
			end
		end
	end

	`QPE_ASSERT(a_held_at_line_start, clk, arst_n, held |-> (column_q == '0))
	`QPE_ASSERT(a_owed_column, clk, arst_n, owed |-> (column_q == MATCH_COL))
	`QPE_ASSERT(a_newline_clean, clk, arst_n, endnl_q |-> (column_q == '0 && prefix_q == PFX_START && !blank_q))

endmodule

@@ rtl/core/qpe_cmd_fifo.sv @@
// command queue between front and back end
module qpe_cmd_fifo import qpe_pkg::*; #(
	parameter int DEPTH = 4
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	input  qpe_cmd_t push_cmd,
	output logic     full,
	input  logic     pop,
	output qpe_cmd_t head,
	output logic     empty
);

	// DEPTH of at least two keeps the pointers one bit wide or more
	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	qpe_cmd_t   mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	logic do_push;
	logic do_pop;

	assign full    = (count_q == CNT_W'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign head    = mem_q[rd_ptr_q];

	function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (do_pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule

@@ rtl/core/qpe_back.sv @@
// back end: walks the segments of each command and sends one character per cycle while enc_stall is low
`include "quoted_printable_encoder_assert.svh"
module qpe_back import qpe_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  qpe_cmd_t cmd_head,
	input  logic     cmd_empty,
	output logic     cmd_pop,
	output logic     enc_valid,
	input  logic     enc_stall,
	output qpe_out_t enc_data
);

	qpe_cmd_t            cmd_q;
	logic                busy_q;
	logic [NUM_SEGS-1:0] mask_q;
	logic [2:0]          idx_q;
	logic                enc_valid_q;
	qpe_out_t            enc_data_q;

	seg_t                sel;
	logic [2:0]          cur_len;
	logic [7:0]          cur_byte;
	logic                seg_done;
	logic [NUM_SEGS-1:0] mask_after;
	logic                fin;
	logic                advance;

	always_comb begin
		sel = SEG_NL;
		for (int i = NUM_SEGS - 1; i >= 0; i--) begin
			if (mask_q[i]) begin
				sel = seg_t'(3'(i));
			end
		end
	end

	always_comb begin
		unique case (sel)
			SEG_PRE: begin
				cur_len  = cmd_q.pre_len;
				cur_byte = pre_char(cmd_q.pre_kind, idx_q);
			end
			SEG_SOFT, SEG_BLANK: begin
				cur_len  = 3'd2;
				cur_byte = (idx_q == 3'd0) ? CH_EQ : CH_LF;
			end
			SEG_BODY: begin
				cur_len = cmd_q.body_hex ? 3'd3 : 3'd1;
				if (!cmd_q.body_hex) begin
					cur_byte = cmd_q.body_byte;
				end else if (idx_q == 3'd0) begin
					cur_byte = CH_EQ;
				end else if (idx_q == 3'd1) begin
					cur_byte = hex_digit(cmd_q.body_byte[7:4]);
				end else begin
					cur_byte = hex_digit(cmd_q.body_byte[3:0]);
				end
			end
			SEG_NL: begin
				cur_len  = 3'd1;
				cur_byte = CH_LF;
			end
			default: begin
				cur_len  = 3'd1;
				cur_byte = CH_LF;
			end
		endcase
	end

	assign seg_done   = (idx_q == cur_len - 3'd1);
	assign mask_after = mask_q & ~(NUM_SEGS'(1) << sel);
	assign fin        = busy_q && seg_done && (mask_after == '0);
	assign advance    = !enc_valid_q || !enc_stall;
	// the next command loads as the last character of this one goes out
	assign cmd_pop    = advance && !cmd_empty && (!busy_q || fin);

	assign enc_valid = enc_valid_q;
	assign enc_data  = enc_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			mask_q      <= '0;
			idx_q       <= '0;
			enc_valid_q <= 1'b0;
		end else if (advance) begin
			enc_valid_q <= busy_q;
			if (cmd_pop) begin
				busy_q <= 1'b1;
				mask_q <= cmd_head.segs;
				idx_q  <= '0;
			end else if (busy_q) begin
				if (seg_done) begin
					mask_q <= mask_after;
					idx_q  <= '0;
				end else begin
					idx_q <= idx_q + 3'd1;
				end
				if (fin) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			cmd_q <= cmd_head;
		end
		if (advance && busy_q) begin
			enc_data_q.out_byte <= cur_byte;
			enc_data_q.run_last <= fin;
		end
	end

	`QPE_ASSERT(a_busy_has_segment, clk, arst_n, busy_q |-> (mask_q != '0))
	`QPE_ASSERT(a_index_in_segment, clk, arst_n, busy_q |-> (idx_q < cur_len))
	`QPE_ASSERT(a_loaded_cmd_nonempty, clk, arst_n, cmd_pop |-> (cmd_head.segs != '0))

endmodule

@@ rtl/core/quoted_printable_encoder.sv @@
// Quoted-printable encoder: one content byte or end mark per src beat, one text
// character per enc beat. The front end takes an item in every cycle while its
// command queue (QUEUE_DEPTH entries) has room; the back end then sends the item's
// 1 to 7 characters at one per cycle from its output register while enc_stall is
// low, so the back-end character sequencer sets the sustained rate. An item that
// causes no character (a held "From" prefix byte, or an end mark after a final
// newline) pushes no command. run_last marks the last character of each item.
// cfg_data sets line_limit (reset 76, values below 8 act as 8); the user must write
// it only while the block is idle, and the block itself does not enforce this.
module quoted_printable_encoder import qpe_pkg::*; #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [7:0] cfg_data,
	input  logic       src_valid,
	output logic       src_stall,
	input  qpe_in_t    src_data,
	output logic       enc_valid,
	input  logic       enc_stall,
	output qpe_out_t   enc_data
);

	logic     cmd_push;
	qpe_cmd_t cmd;
	logic     cmd_full;
	logic     cmd_pop;
	qpe_cmd_t cmd_head;
	logic     cmd_empty;

	qpe_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.src_valid (src_valid),
		.src_stall (src_stall),
		.src_data  (src_data),
		.cmd_push  (cmd_push),
		.cmd       (cmd),
		.cmd_full  (cmd_full)
	);

	qpe_cmd_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (cmd_push),
		.push_cmd (cmd),
		.full     (cmd_full),
		.pop      (cmd_pop),
		.head     (cmd_head),
		.empty    (cmd_empty)
	);

	qpe_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_head  (cmd_head),
		.cmd_empty (cmd_empty),
		.cmd_pop   (cmd_pop),
		.enc_valid (enc_valid),
		.enc_stall (enc_stall),
		.enc_data  (enc_data)
	);

endmodule

@@ verif/quoted_printable_encoder_tb.sv @@
// self-checking testbench for the quoted-printable encoder: table-driven and random byte streams
`timescale 1ns / 1ps

module quoted_printable_encoder_tb;
	import qpe_pkg::*;

	localparam int CYCLE_LIMIT     = 200000;
	localparam int DRAIN_CYCLES    = 24;
	localparam int MAX_CHARS       = 8;
	localparam int ITEMS_PER_PHASE = 50;
	localparam int NUM_PHASES      = 6;
	localparam int HOLD_AT_ITEM    = 80;
	localparam int HOLD_CYCLES     = 300;
	localparam int QUIET_FROM      = 150;
	localparam int QUIET_TO        = 230;
	localparam int MAX_PRINTED     = 50;

	// prefix tracker: 1..4 are counts of held "From" bytes
	localparam int PFX_LINE_START = 0;
	localparam int PFX_HELD_ALL   = 4;
	localparam int PFX_PAST       = 5;
	localparam int PFX_OWED       = 6;

	typedef enum logic {
		ROW_ITEM,
		ROW_LIMIT
	} row_op_t;

	typedef struct {
		row_op_t    op;
		logic       kind;
		logic [7:0] value;
		string      typed;
	} stim_row_t;

	logic       clk;
	logic       arst_n;
	logic       cfg_valid;
	logic       cfg_ready;
	logic [7:0] cfg_data;
	logic       src_valid;
	logic       src_stall;
	qpe_in_t    src_data;
	logic       enc_valid;
	logic       enc_stall;
	qpe_out_t   enc_data;

	quoted_printable_encoder dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.src_valid (src_valid),
		.src_stall (src_stall),
		.src_data  (src_data),
		.enc_valid (enc_valid),
		.enc_stall (enc_stall),
		.enc_data  (enc_data)
	);

	// encoder state mirrored for prediction
	logic [7:0] line_limit_q = LIMIT_RESET;
	int         column_q;
	int         prefix_q;
	logic       blank_tail_q = 1'b0;
	logic       newline_tail_q = 1'b0;

	logic [7:0] from_word [5] = '{CH_F, CH_R, CH_O, CH_M, CH_SP};
	string      hex_chars = "0123456789ABCDEF";

	qpe_out_t expected_chars [$];
	int       items_accepted;
	int       end_marks;
	int       from_matches;
	int       chars_checked;
	int       limit_writes;
	int       mismatches;
	int       cycle_count;
	bit       hold_done;

	stim_row_t directed_rows [$] = '{
		'{ROW_ITEM,  1'b0, 8'h00, "=00"},
		'{ROW_ITEM,  1'b0, 8'hFF, "=FF"},
		'{ROW_ITEM,  1'b0, 8'h3D, "=3D"},
		'{ROW_ITEM,  1'b0, 8'h09, "\t"},
		'{ROW_ITEM,  1'b0, 8'h0A, "=\n\n"},
		'{ROW_ITEM,  1'b0, "F",   ""},
		'{ROW_ITEM,  1'b0, "r",   ""},
		'{ROW_ITEM,  1'b0, "o",   ""},
		'{ROW_ITEM,  1'b0, "m",   ""},
		'{ROW_ITEM,  1'b0, 8'h20, "=46rom "},
		'{ROW_ITEM,  1'b0, 8'h0A, "=\n\n"},
		'{ROW_ITEM,  1'b0, "F",   ""},
		'{ROW_ITEM,  1'b0, 8'h0A, "F\n"},
		'{ROW_ITEM,  1'b1, 8'hFF, ""},
		'{ROW_ITEM,  1'b1, 8'h00, "\n"},
		'{ROW_LIMIT, 1'b0, 8'h00, ""},
		'{ROW_ITEM,  1'b0, "F",   ""},
		'{ROW_ITEM,  1'b0, "r",   ""},
		'{ROW_ITEM,  1'b0, "o",   ""},
		'{ROW_ITEM,  1'b0, "m",   ""},
		'{ROW_ITEM,  1'b0, 8'h20, "=46rom"},
		'{ROW_ITEM,  1'b1, 8'h00, "=\n \n"},
		'{ROW_ITEM,  1'b0, "F",   ""},
		'{ROW_ITEM,  1'b0, "r",   ""},
		'{ROW_ITEM,  1'b0, "o",   ""},
		'{ROW_ITEM,  1'b0, "m",   ""},
		'{ROW_ITEM,  1'b0, 8'h20, "=46rom"},
		'{ROW_ITEM,  1'b0, "a",   "=\n a"}
	};

	initial clk = 1'b0;
	always #5 clk = ~clk;

	task automatic note_mismatch(input string msg);
		if (mismatches < MAX_PRINTED)
			$display("mismatch at cycle %0d: %s", cycle_count, msg);
		mismatches++;
	endtask

	function automatic int limit_cols();
		return (line_limit_q < LIMIT_MIN) ? int'(LIMIT_MIN) : int'(line_limit_q);
	endfunction

	function automatic void push_char(ref qpe_out_t q [$], input logic [7:0] c);
		if (q.size() < MAX_CHARS)
			q.push_back('{out_byte: c, run_last: 1'b0});
	endfunction

	function automatic void encode_char(ref qpe_out_t q [$], input logic [7:0] b);
		logic blank;
		blank = (b == CH_SP) || (b == CH_TAB);
		if (column_q + 3 > limit_cols()) begin
			push_char(q, CH_EQ);
			push_char(q, CH_LF);
			column_q = 0;
		end
		if (blank || (b >= CH_BANG && b <= CH_TILDE && b != CH_EQ)) begin
			push_char(q, b);
			column_q += 1;
		end else begin
			push_char(q, CH_EQ);
			push_char(q, hex_chars[b[7:4]]);
			push_char(q, hex_chars[b[3:0]]);
			column_q += 3;
		end
		column_q &= 8'hFF;
		blank_tail_q = blank;
	endfunction

	// held "From" bytes go out as text; an owed match finishes with soft break and space
	function automatic void release_prefix(ref qpe_out_t q [$]);
		int held;
		held = prefix_q;
		if (held >= 1 && held <= PFX_HELD_ALL) begin
			for (int i = 0; i < held; i++)
				encode_char(q, from_word[i]);
			prefix_q = PFX_PAST;
		end else if (held == PFX_OWED) begin
			push_char(q, CH_EQ);
			push_char(q, CH_LF);
			push_char(q, CH_SP);
			column_q = 1;
			blank_tail_q = 1'b1;
			prefix_q = PFX_PAST;
		end
	endfunction

	function automatic void predict_encoding(input qpe_in_t it, ref qpe_out_t q [$]);
		logic [7:0] b;
		b = it.data_byte;
		q = {};
		if (it.kind) begin
			release_prefix(q);
			if (!newline_tail_q)
				push_char(q, CH_LF);
			column_q = 0;
			prefix_q = PFX_LINE_START;
			blank_tail_q = 1'b0;
			newline_tail_q = 1'b0;
		end else if (b == CH_LF) begin
			release_prefix(q);
			if (blank_tail_q) begin
				push_char(q, CH_EQ);
				push_char(q, CH_LF);
			end
			push_char(q, CH_LF);
			column_q = 0;
			prefix_q = PFX_LINE_START;
			blank_tail_q = 1'b0;
			newline_tail_q = 1'b1;
		end else begin
			newline_tail_q = 1'b0;
			if (prefix_q == PFX_OWED)
				release_prefix(q);
			if (prefix_q < PFX_HELD_ALL && b == from_word[prefix_q]) begin
				prefix_q++;
			end else if (prefix_q == PFX_HELD_ALL && b == CH_SP) begin
				from_matches++;
				push_char(q, CH_EQ);
				push_char(q, CH_4);
				push_char(q, CH_6);
				column_q = 3;
				encode_char(q, CH_R);
				encode_char(q, CH_O);
				encode_char(q, CH_M);
				if (column_q + 3 > limit_cols()) begin
					prefix_q = PFX_OWED;
				end else begin
					encode_char(q, b);
					prefix_q = PFX_PAST;
				end
			end else begin
				release_prefix(q);
				prefix_q = PFX_PAST;
				encode_char(q, b);
			end
		end
		if (q.size() > 0)
			q[q.size() - 1].run_last = 1'b1;
	endfunction

	function automatic qpe_in_t content_item(input logic [7:0] b);
		return '{kind: 1'b0, data_byte: b};
	endfunction

	function automatic bit quiet_now();
		return items_accepted >= QUIET_FROM && items_accepted < QUIET_TO;
	endfunction

	// offer one beat, hold it until taken, then record what it should produce
	task automatic send_item(input qpe_in_t it, input string typed);
		qpe_out_t chars [$];
		bit       typed_ok;
		if (!quiet_now() && $urandom_range(99) < 16) begin
			src_valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		src_valid <= 1'b1;
		src_data  <= it;
		do @(posedge clk); while (src_stall);
		items_accepted++;
		if (it.kind)
			end_marks++;
		predict_encoding(it, chars);
		if (typed.len() != 0) begin
			typed_ok = (chars.size() == typed.len());
			for (int i = 0; i < typed.len() && typed_ok; i++)
				typed_ok = (chars[i].out_byte == typed[i]);
			if (!typed_ok)
				note_mismatch($sformatf("item %0d: table text disagrees with prediction",
					items_accepted));
			chars = {};
			foreach (typed[i])
				chars.push_back('{out_byte: typed[i], run_last: (i == typed.len() - 1)});
		end
		foreach (chars[i])
			expected_chars.push_back(chars[i]);
	endtask

	task automatic settle();
		src_valid <= 1'b0;
		while (expected_chars.size() != 0)
			@(posedge clk);
		// an item with no characters may still be in flight
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_limit(input logic [7:0] value);
		settle();
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		line_limit_q = value;
		limit_writes++;
	endtask

	function automatic logic [7:0] random_content_byte();
		int pick;
		pick = $urandom_range(99);
		if (pick < 40)
			return 8'($urandom_range(8'h21, 8'h7E));
		if (pick < 55)
			return $urandom_range(1) ? CH_SP : CH_TAB;
		if (pick < 62)
			return CH_EQ;
		if (pick < 90)
			return 8'($urandom_range(255));
		return CH_F;
	endfunction

	// mostly whole lines, some opening with "From " or a broken prefix
	task automatic send_random_line();
		qpe_in_t    line [$];
		int         pick;
		int         held;
		int         len;
		bit         long_line;
		logic [7:0] b;
		pick = $urandom_range(9);
		if (pick <= 2) begin
			foreach (from_word[i])
				line.push_back(content_item(from_word[i]));
		end else if (pick <= 4) begin
			held = $urandom_range(1, 4);
			for (int i = 0; i < held; i++)
				line.push_back(content_item(from_word[i]));
			if ($urandom_range(9) == 0)
				line.push_back('{kind: 1'b1, data_byte: 8'($urandom_range(255))});
			else
				line.push_back(content_item(random_content_byte()));
		end
		long_line = ($urandom_range(19) == 0);
		len = long_line ? $urandom_range(90, 110) : $urandom_range(0, 24);
		for (int i = 0; i < len; i++) begin
			b = long_line ? 8'($urandom_range(8'h80, 8'hFF)) : random_content_byte();
			line.push_back(content_item(b));
		end
		if ($urandom_range(3) == 0)
			line.push_back(content_item($urandom_range(1) ? CH_SP : CH_TAB));
		pick = $urandom_range(9);
		if (pick < 7)
			line.push_back(content_item(CH_LF));
		if (pick == 9 || $urandom_range(19) == 0)
			line.push_back('{kind: 1'b1, data_byte: 8'($urandom_range(255))});
		foreach (line[i])
			send_item(line[i], "");
	endtask

	// output side: random stall, one long hold-off while input keeps coming
	initial begin
		int hold_count;
		enc_stall = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (!hold_done && items_accepted >= HOLD_AT_ITEM) begin
				hold_done = 1'b1;
				enc_stall <= 1'b1;
				hold_count = 0;
				while (hold_count < HOLD_CYCLES) begin
					@(posedge clk);
					hold_count++;
				end
				enc_stall <= 1'b0;
			end else begin
				enc_stall <= !quiet_now() && ($urandom_range(99) < 16);
			end
		end
	end

	always @(posedge clk) begin : check_output
		qpe_out_t want;
		if (arst_n && enc_valid && !enc_stall) begin
			if (expected_chars.size() == 0) begin
				note_mismatch($sformatf("unexpected char %h", enc_data.out_byte));
			end else begin
				want = expected_chars.pop_front();
				chars_checked++;
				if (enc_data.out_byte !== want.out_byte)
					note_mismatch($sformatf("out_byte %h, wanted %h",
						enc_data.out_byte, want.out_byte));
				if (enc_data.run_last !== want.run_last)
					note_mismatch($sformatf("run_last %b, wanted %b on char %h",
						enc_data.run_last, want.run_last, want.out_byte));
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout with %0d chars outstanding", expected_chars.size());
			$display("FAIL quoted_printable_encoder");
			$finish;
		end
	end

	initial begin
		logic [7:0] phase_limits [NUM_PHASES];
		int         target;
		phase_limits = '{8'd255, 8'd8, 8'd3, 8'($urandom_range(9, 254)), 8'd20, LIMIT_RESET};
		arst_n    = 1'b0;
		src_valid = 1'b0;
		src_data  = '0;
		cfg_valid = 1'b0;
		cfg_data  = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (directed_rows[r]) begin
			if (directed_rows[r].op == ROW_LIMIT)
				write_limit(directed_rows[r].value);
			else
				send_item('{kind: directed_rows[r].kind, data_byte: directed_rows[r].value},
					directed_rows[r].typed);
		end
		for (int phase = 0; phase < NUM_PHASES; phase++) begin
			write_limit(phase_limits[phase]);
			target = items_accepted + ITEMS_PER_PHASE;
			while (items_accepted < target)
				send_random_line();
		end
		settle();
		$display("covered %0d input beats (%0d end marks, %0d \"From \" lines) over %0d limit writes",
			items_accepted, end_marks, from_matches, limit_writes);
		$display("checked %0d output chars, %0d mismatches", chars_checked, mismatches);
		if (mismatches == 0)
			$display("PASS quoted_printable_encoder");
		else
			$display("FAIL quoted_printable_encoder");
		$finish;
	end

endmodule

@@ files.f @@
+incdir+rtl/core
rtl/core/qpe_pkg.sv
rtl/core/qpe_front.sv
rtl/core/qpe_cmd_fifo.sv
rtl/core/qpe_back.sv
rtl/core/quoted_printable_encoder.sv
verif/quoted_printable_encoder_tb.sv
